// ===== rtl/core/counter_based_flood_suppressor_macros.svh =====
// ---------------------------------------------------------------------------
// counter_based_flood_suppressor_macros.svh
// assertion shorthands for the flood suppressor
// ---------------------------------------------------------------------------
`ifndef COUNTER_BASED_FLOOD_SUPPRESSOR_MACROS_SVH
`define COUNTER_BASED_FLOOD_SUPPRESSOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cbfs_pkg.sv =====
// ---------------------------------------------------------------------------
// cbfs_pkg
// types and codes shared by the flood suppressor
// ---------------------------------------------------------------------------
package cbfs_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MSG_W   = 32;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned OUT_W   = 48;

  localparam logic [KIND_W-1:0] KIND_RX     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;
  localparam logic [CFG_W-1:0]   ALLOWED_RESET = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEN_SCAN,
    ST_PEND_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // result flags, last field in the lowest bit
  typedef struct packed {
    logic               table_full;
    logic [COUNT_W-1:0] copies;
    logic               forward;
    logic               cancel_timer;
    logic               start_timer;
    logic               first_reception;
  } res_t;

endpackage

// ===== rtl/core/counter_based_flood_suppressor.sv =====
// ---------------------------------------------------------------------------
// counter_based_flood_suppressor
// counter based broadcast suppression over a seen table and a pending table
// ---------------------------------------------------------------------------
// One event is handled at a time and every event gives exactly one result beat.
// A reception walks the seen-id memory one entry a cycle (as many entries as
// have been filled, at most SEEN_DEPTH), then the pending memory (PEND_DEPTH
// entries), stopping early on a match; the memory reads are registered.
// A timer expiry walks the pending memory only; a clear or an unused kind
// walks neither memory. The next event is taken while the previous result
// still waits in the output register. The seen table is filled in order and
// tracked by a fill count, so no clearing pass is needed after reset.
module counter_based_flood_suppressor #(
  parameter int unsigned SEEN_DEPTH = 64,
  parameter int unsigned PEND_DEPTH = 16,
  parameter int unsigned ID_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config beat: allowed_receptions
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbfs_pkg::CFG_W-1:0]    cfg_data,
  // in_tdata: msg_id[31:0]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cbfs_pkg::MSG_W-1:0]    in_tdata,
  // in_tuser: kind[1:0]
  input  logic [cbfs_pkg::KIND_W-1:0]   in_tuser,
  // out_tdata: out_msg_id[31:0], first_reception[32], start_timer[33],
  // cancel_timer[34], forward[35], copies[43:36], table_full[44], zero[47:45]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cbfs_pkg::OUT_W-1:0]    out_tdata
);

  localparam int unsigned SA_W   = $clog2(SEEN_DEPTH);
  localparam int unsigned PA_W   = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int unsigned CNT_W  = ((SA_W > PA_W) ? SA_W : PA_W) + 1;
  localparam int unsigned PE_W   = ID_WIDTH + cbfs_pkg::COUNT_W;
  localparam int unsigned PAD_W  = cbfs_pkg::OUT_W - cbfs_pkg::MSG_W - $bits(cbfs_pkg::res_t);

  // memories
  logic [ID_WIDTH-1:0] seen_mem [SEEN_DEPTH];
  logic [PE_W-1:0]     pend_mem [PEND_DEPTH];

  cbfs_pkg::state_t state_r, state_nxt;

  logic [cbfs_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [ID_WIDTH-1:0]          id_r, id_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [PA_W-1:0]              rd_idx_r, rd_idx_nxt;
  logic                         seen_hit_r, seen_hit_nxt;
  logic                         match_r, match_nxt;
  logic [PA_W-1:0]              match_idx_r, match_idx_nxt;
  logic [cbfs_pkg::COUNT_W-1:0] match_cnt_r, match_cnt_nxt;
  logic                         free_r, free_nxt;
  logic [PA_W-1:0]              free_idx_r, free_idx_nxt;
  logic [cbfs_pkg::CFG_W-1:0]   allowed_r, allowed_nxt;
  logic [SA_W-1:0]              seen_slot_r, seen_slot_nxt;
  logic [SA_W:0]                seen_fill_r, seen_fill_nxt;
  logic [PEND_DEPTH-1:0]        pend_valid_r, pend_valid_nxt;
  cbfs_pkg::res_t               res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [cbfs_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;

  logic                         seen_re, seen_we;
  logic [SA_W-1:0]              seen_raddr;
  logic [ID_WIDTH-1:0]          seen_rdata_r;
  logic                         pend_re, pend_we;
  logic [PA_W-1:0]              pend_raddr, pend_waddr;
  logic [PE_W-1:0]              pend_wdata;
  logic [PE_W-1:0]              pend_rdata_r;

  logic                         in_beat;
  logic [63:0]                  in_id_ext;
  logic [63:0]                  id_ext;
  logic                         seen_cmp_hit;
  logic                         seen_done;
  logic                         pend_cmp_hit;
  logic                         pend_done;
  logic [cbfs_pkg::COUNT_W-1:0] cnt_inc;
  logic                         out_free;

  assign in_beat   = in_tvalid & in_tready;
  assign in_id_ext = 64'(in_tdata);
  assign id_ext    = 64'(id_r);
  assign out_free  = !out_valid_r || out_tready;

  // compares against the data read in the previous cycle
  assign seen_cmp_hit = rd_vld_r && (seen_rdata_r == id_r);
  assign seen_done    = seen_cmp_hit || (cnt_r >= CNT_W'(seen_fill_r));
  assign pend_cmp_hit = rd_vld_r && pend_valid_r[rd_idx_r] &&
                        (pend_rdata_r[PE_W-1:cbfs_pkg::COUNT_W] == id_r);
  assign pend_done    = pend_cmp_hit || (cnt_r >= CNT_W'(PEND_DEPTH));
  assign cnt_inc      = (match_cnt_r == cbfs_pkg::COUNT_MAX) ? match_cnt_r
                                                             : match_cnt_r + 8'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbfs_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (in_tuser == cbfs_pkg::KIND_RX) begin
            state_nxt = cbfs_pkg::ST_SEEN_SCAN;
          end else if (in_tuser == cbfs_pkg::KIND_EXPIRY) begin
            state_nxt = cbfs_pkg::ST_PEND_SCAN;
          end else begin
            state_nxt = cbfs_pkg::ST_UPDATE;
          end
        end
      end
      cbfs_pkg::ST_SEEN_SCAN: begin
        if (seen_done) state_nxt = cbfs_pkg::ST_PEND_SCAN;
      end
      cbfs_pkg::ST_PEND_SCAN: begin
        if (pend_done) state_nxt = cbfs_pkg::ST_UPDATE;
      end
      cbfs_pkg::ST_UPDATE: state_nxt = cbfs_pkg::ST_RESP;
      cbfs_pkg::ST_RESP: begin
        if (out_free) state_nxt = cbfs_pkg::ST_IDLE;
      end
      default: state_nxt = cbfs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_tready = 1'b0;
    seen_re   = 1'b0;
    pend_re   = 1'b0;
    unique case (state_r)
      cbfs_pkg::ST_IDLE:      in_tready = 1'b1;
      cbfs_pkg::ST_SEEN_SCAN: seen_re   = (cnt_r < CNT_W'(seen_fill_r));
      cbfs_pkg::ST_PEND_SCAN: pend_re   = (cnt_r < CNT_W'(PEND_DEPTH));
      cbfs_pkg::ST_UPDATE,
      cbfs_pkg::ST_RESP:      in_tready = 1'b0;
      default:                in_tready = 1'b0;
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign seen_raddr = cnt_r[SA_W-1:0];
  assign pend_raddr = cnt_r[PA_W-1:0];

  // datapath
  always_comb begin
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    seen_hit_nxt   = seen_hit_r;
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    match_cnt_nxt  = match_cnt_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    allowed_nxt    = allowed_r;
    seen_slot_nxt  = seen_slot_r;
    seen_fill_nxt  = seen_fill_r;
    pend_valid_nxt = pend_valid_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    seen_we        = 1'b0;
    pend_we        = 1'b0;
    pend_waddr     = match_idx_r;
    pend_wdata     = {id_r, match_cnt_r};

    if (cfg_valid && cfg_ready) allowed_nxt = cfg_data;

    case (state_r)
      cbfs_pkg::ST_IDLE: begin
        if (in_beat) begin
          kind_nxt     = in_tuser;
          id_nxt       = in_id_ext[ID_WIDTH-1:0];
          cnt_nxt      = '0;
          seen_hit_nxt = 1'b0;
          match_nxt    = 1'b0;
          free_nxt     = 1'b0;
        end
      end
      cbfs_pkg::ST_SEEN_SCAN: begin
        if (seen_re) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (seen_done) begin
          seen_hit_nxt = seen_cmp_hit;
          cnt_nxt      = '0;
          rd_vld_nxt   = 1'b0;
        end
      end
      cbfs_pkg::ST_PEND_SCAN: begin
        if (pend_re) begin
          cnt_nxt    = cnt_r + 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = pend_raddr;
        end
        if (rd_vld_r && !pend_valid_r[rd_idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
        if (pend_cmp_hit) begin
          match_nxt     = 1'b1;
          match_idx_nxt = rd_idx_r;
          match_cnt_nxt = pend_rdata_r[cbfs_pkg::COUNT_W-1:0];
        end
        if (pend_done) rd_vld_nxt = 1'b0;
      end
      cbfs_pkg::ST_UPDATE: begin
        res_nxt = '0;
        if (kind_r == cbfs_pkg::KIND_RX) begin
          if (!seen_hit_r) begin
            // unseen id: record it, reuse a pending entry or open a free one, else flag table full
            res_nxt.first_reception = 1'b1;
            seen_we       = 1'b1;
            seen_slot_nxt = (seen_slot_r == SA_W'(SEEN_DEPTH - 1)) ? '0
                                                                   : seen_slot_r + 1'b1;
            if (seen_fill_r != (SA_W + 1)'(SEEN_DEPTH)) seen_fill_nxt = seen_fill_r + 1'b1;
            if (match_r || free_r) begin
              pend_we    = 1'b1;
              pend_waddr = match_r ? match_idx_r : free_idx_r;
              pend_wdata = {id_r, cbfs_pkg::COUNT_ONE};
              pend_valid_nxt[pend_waddr] = 1'b1;
              res_nxt.start_timer = 1'b1;
              res_nxt.copies      = cbfs_pkg::COUNT_ONE;
            end else begin
              res_nxt.table_full = 1'b1;
            end
          end else if (match_r) begin
            pend_we        = 1'b1;
            pend_wdata     = {id_r, cnt_inc};
            res_nxt.copies = cnt_inc;
            if (cnt_inc >= allowed_r) begin
              pend_valid_nxt[match_idx_r] = 1'b0;
              res_nxt.cancel_timer        = 1'b1;
            end
          end
        end else if (kind_r == cbfs_pkg::KIND_EXPIRY) begin
          if (match_r) begin
            res_nxt.copies              = match_cnt_r;
            res_nxt.forward             = (match_cnt_r < allowed_r);
            pend_valid_nxt[match_idx_r] = 1'b0;
          end
        end else if (kind_r == cbfs_pkg::KIND_CLEAR) begin
          pend_valid_nxt = '0;
        end
      end
      cbfs_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {PAD_W'(0), res_r, id_ext[cbfs_pkg::MSG_W-1:0]};
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cbfs_pkg::ST_IDLE;
      rd_vld_r     <= 1'b0;
      allowed_r    <= cbfs_pkg::ALLOWED_RESET;
      seen_slot_r  <= '0;
      seen_fill_r  <= '0;
      pend_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      allowed_r    <= allowed_nxt;
      seen_slot_r  <= seen_slot_nxt;
      seen_fill_r  <= seen_fill_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    id_r        <= id_nxt;
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    seen_hit_r  <= seen_hit_nxt;
    match_r     <= match_nxt;
    match_idx_r <= match_idx_nxt;
    match_cnt_r <= match_cnt_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // seen-id memory
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_slot_r] <= id_r;
    if (seen_re) seen_rdata_r <= seen_mem[seen_raddr];
  end

  // pending memory: id and copy count per entry
  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_re) pend_rdata_r <= pend_mem[pend_raddr];
  end

`include "counter_based_flood_suppressor_macros.svh"

  `CBFS_ASSERT_NOW(a_start_is_first, out_valid_r && out_data_r[33], out_data_r[32] && (out_data_r[43:36] == cbfs_pkg::COUNT_ONE), "start without first reception at count one")
  `CBFS_ASSERT_NOW(a_full_no_start, out_valid_r && out_data_r[44], out_data_r[32] && !out_data_r[33] && (out_data_r[43:36] == '0), "table full result inconsistent")
  `CBFS_ASSERT_NOW(a_cancel_at_threshold, out_valid_r && out_data_r[34], (out_data_r[43:36] >= allowed_r) && !out_data_r[32], "cancel below threshold")
  `CBFS_ASSERT_NOW(a_fill_bound, 1'b1, seen_fill_r <= (SA_W + 1)'(SEEN_DEPTH), "seen fill count overflow")
  `CBFS_ASSERT_NEXT(a_update_to_resp, state_r == cbfs_pkg::ST_UPDATE, state_r == cbfs_pkg::ST_RESP, "update not followed by response")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// checks the flood suppressor against a cycle-free model of its two tables:
// every accepted event gives one expected result beat, compared field by
// field with the beats that leave the block under random idling and stalls
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned SEEN_N       = 64;
  localparam int unsigned PEND_N       = 16;
  localparam int unsigned HOT_N        = 20;
  localparam int unsigned WIDE_SPAN    = 96;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned SETTLE       = 8;
  localparam logic [cbfs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [cbfs_pkg::MSG_W-1:0] msg_id;
    cbfs_pkg::res_t             flags;
  } verdict_t;

  class suppression_scoreboard;
    logic [cbfs_pkg::MSG_W-1:0]   seen_id [SEEN_N];
    bit                           seen_ok [SEEN_N];
    int unsigned                  seen_wr;
    logic [cbfs_pkg::MSG_W-1:0]   pend_id [PEND_N];
    logic [cbfs_pkg::COUNT_W-1:0] pend_cnt [PEND_N];
    bit                           pend_ok [PEND_N];
    logic [cbfs_pkg::CFG_W-1:0]   allowed;
    verdict_t                     verdict_q [$];
    int unsigned                  mismatches;

    function new();
      foreach (seen_ok[i]) seen_ok[i] = 1'b0;
      foreach (pend_ok[i]) pend_ok[i] = 1'b0;
      seen_wr    = 0;
      allowed    = cbfs_pkg::ALLOWED_RESET;
      mismatches = 0;
    endfunction

    function void set_allowed(logic [cbfs_pkg::CFG_W-1:0] value);
      allowed = value;
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction

    function int find_pending(logic [cbfs_pkg::MSG_W-1:0] id);
      foreach (pend_ok[i])
        if (pend_ok[i] && pend_id[i] == id) return i;
      return -1;
    endfunction

    // works out the result of one accepted event and updates both tables
    function void note_event(logic [cbfs_pkg::KIND_W-1:0] kind,
                             logic [cbfs_pkg::MSG_W-1:0] id);
      verdict_t v;
      int       hit;
      bit       known;
      v.msg_id = id;
      v.flags  = '0;
      hit      = find_pending(id);
      case (kind)
        cbfs_pkg::KIND_RX: begin
          known = 1'b0;
          foreach (seen_ok[i])
            if (seen_ok[i] && seen_id[i] == id) known = 1'b1;
          if (!known) begin
            v.flags.first_reception = 1'b1;
            seen_id[seen_wr] = id;
            seen_ok[seen_wr] = 1'b1;
            seen_wr = (seen_wr + 1) % SEEN_N;
            // an id evicted from the seen table may still hold its entry
            if (hit < 0)
              foreach (pend_ok[i])
                if (!pend_ok[i] && hit < 0) hit = i;
            if (hit < 0) begin
              v.flags.table_full = 1'b1;
            end else begin
              pend_id[hit]  = id;
              pend_cnt[hit] = cbfs_pkg::COUNT_ONE;
              pend_ok[hit]  = 1'b1;
              v.flags.start_timer = 1'b1;
              v.flags.copies      = cbfs_pkg::COUNT_ONE;
            end
          end else if (hit >= 0) begin
            if (pend_cnt[hit] != cbfs_pkg::COUNT_MAX) pend_cnt[hit] = pend_cnt[hit] + 1'b1;
            v.flags.copies = pend_cnt[hit];
            if (pend_cnt[hit] >= allowed) begin
              pend_ok[hit] = 1'b0;
              v.flags.cancel_timer = 1'b1;
            end
          end
        end
        cbfs_pkg::KIND_EXPIRY: begin
          if (hit >= 0) begin
            v.flags.copies  = pend_cnt[hit];
            v.flags.forward = (pend_cnt[hit] < allowed);
            pend_ok[hit]    = 1'b0;
          end
        end
        cbfs_pkg::KIND_CLEAR: begin
          foreach (pend_ok[i]) pend_ok[i] = 1'b0;
        end
        default: ;
      endcase
      verdict_q.push_back(v);
    endfunction

    function void check_field(string name, logic [cbfs_pkg::MSG_W-1:0] want,
                              logic [cbfs_pkg::MSG_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [cbfs_pkg::OUT_W-1:0] beat);
      verdict_t       want;
      cbfs_pkg::res_t got;
      if (verdict_q.size() == 0) begin
        $error("result beat %0h with no event outstanding", beat);
        mismatches++;
        return;
      end
      want = verdict_q.pop_front();
      got  = beat[cbfs_pkg::MSG_W +: $bits(cbfs_pkg::res_t)];
      check_field("out_msg_id", want.msg_id, beat[cbfs_pkg::MSG_W-1:0]);
      check_field("first_reception", want.flags.first_reception, got.first_reception);
      check_field("start_timer", want.flags.start_timer, got.start_timer);
      check_field("cancel_timer", want.flags.cancel_timer, got.cancel_timer);
      check_field("forward", want.flags.forward, got.forward);
      check_field("copies", want.flags.copies, got.copies);
      check_field("table_full", want.flags.table_full, got.table_full);
      check_field("padding", '0,
                  beat[cbfs_pkg::OUT_W-1:cbfs_pkg::MSG_W+$bits(cbfs_pkg::res_t)]);
    endfunction
  endclass

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [cbfs_pkg::CFG_W-1:0]   cfg_data   = '0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [cbfs_pkg::MSG_W-1:0]   in_tdata   = '0;
  logic [cbfs_pkg::KIND_W-1:0]  in_tuser   = cbfs_pkg::KIND_RX;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [cbfs_pkg::OUT_W-1:0]   out_tdata;

  int unsigned                  in_idle_pct   = 0;
  int unsigned                  out_stall_pct = 0;
  int unsigned                  events_sent   = 0;
  logic [cbfs_pkg::MSG_W-1:0]   hot_ids [HOT_N];
  logic [cbfs_pkg::MSG_W-1:0]   wide_base;

  suppression_scoreboard suppressor_sb = new();

  counter_based_flood_suppressor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) suppressor_sb.check_beat(out_tdata);
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_event(input logic [cbfs_pkg::KIND_W-1:0] kind,
                            input logic [cbfs_pkg::MSG_W-1:0] id);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= id;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    suppressor_sb.note_event(kind, id);
    events_sent++;
  endtask

  task automatic wait_idle(input int unsigned settle);
    in_tvalid <= 1'b0;
    while (suppressor_sb.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_allowed(input logic [cbfs_pkg::CFG_W-1:0] value);
    wait_idle(SETTLE);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    suppressor_sb.set_allowed(value);
  endtask

  function automatic logic [cbfs_pkg::MSG_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return hot_ids[$urandom_range(HOT_N-1)];
    if (r < 92) return wide_base + $urandom_range(WIDE_SPAN-1);
    return $urandom;
  endfunction

  // one message seen through: first copy, a few duplicates, then mostly its expiry
  task automatic message_life();
    logic [cbfs_pkg::MSG_W-1:0] id;
    id = pick_id();
    send_event(cbfs_pkg::KIND_RX, id);
    repeat ($urandom_range(0, 4)) send_event(cbfs_pkg::KIND_RX, id);
    if ($urandom_range(99) < 70) send_event(cbfs_pkg::KIND_EXPIRY, id);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned                 target;
    int unsigned                 r;
    logic [cbfs_pkg::KIND_W-1:0] kind;
    target = events_sent + count;
    while (events_sent < target) begin
      if ($urandom_range(99) < 80) begin
        message_life();
      end else begin
        r = $urandom_range(99);
        kind = (r < 40) ? cbfs_pkg::KIND_RX : (r < 80) ? cbfs_pkg::KIND_EXPIRY :
               (r < 90) ? cbfs_pkg::KIND_CLEAR : KIND_UNUSED;
        send_event(kind, pick_id());
      end
    end
  endtask

  // more fresh ids than the seen table holds, then the first one again:
  // fills the pending table and evicts an id that is still pending
  task automatic seen_flood();
    logic [cbfs_pkg::MSG_W-1:0] base;
    base = $urandom;
    for (int i = 0; i <= SEEN_N + 1; i++) send_event(cbfs_pkg::KIND_RX, base + i);
    send_event(cbfs_pkg::KIND_RX, base);
  endtask

  task automatic refresh_pools();
    foreach (hot_ids[i]) hot_ids[i] = $urandom;
    hot_ids[0] = '0;
    hot_ids[1] = '1;
    wide_base  = $urandom;
  endtask

  initial begin
    logic [cbfs_pkg::CFG_W-1:0] phase_allowed [6];
    logic [cbfs_pkg::MSG_W-1:0] long_id;
    phase_allowed = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd3};
    phase_allowed[5] = $urandom_range(4, 254);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: threshold at its reset value first
    send_event(cbfs_pkg::KIND_RX, 32'h0000_0000);
    send_event(cbfs_pkg::KIND_RX, 32'h0000_0000);
    send_event(cbfs_pkg::KIND_RX, 32'h0000_0000);
    send_event(cbfs_pkg::KIND_RX, 32'h0000_0000);
    send_event(cbfs_pkg::KIND_RX, 32'hFFFF_FFFF);
    send_event(cbfs_pkg::KIND_EXPIRY, 32'hFFFF_FFFF);
    send_event(cbfs_pkg::KIND_EXPIRY, 32'hFFFF_FFFF);
    send_event(cbfs_pkg::KIND_RX, 32'hA5A5_5A5A);
    send_event(cbfs_pkg::KIND_RX, 32'hA5A5_5A5A);
    // lowering the threshold to the count: expiry drops without forwarding
    write_allowed(8'd2);
    send_event(cbfs_pkg::KIND_EXPIRY, 32'hA5A5_5A5A);
    send_event(cbfs_pkg::KIND_RX, 32'h1234_5678);
    send_event(cbfs_pkg::KIND_RX, 32'h8765_4321);
    send_event(cbfs_pkg::KIND_CLEAR, 32'h5555_AAAA);
    send_event(cbfs_pkg::KIND_EXPIRY, 32'h1234_5678);
    send_event(cbfs_pkg::KIND_RX, 32'h1234_5678);
    send_event(KIND_UNUSED, 32'hAAAA_5555);
    write_allowed(8'd0);
    send_event(cbfs_pkg::KIND_RX, 32'h0F0F_0F0F);
    send_event(cbfs_pkg::KIND_RX, 32'h0F0F_0F0F);
    send_event(cbfs_pkg::KIND_RX, 32'hC3C3_C3C3);
    send_event(cbfs_pkg::KIND_EXPIRY, 32'hC3C3_C3C3);

    for (int p = 0; p < 6; p++) begin
      wait_idle(SETTLE);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 55; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 37; out_stall_pct = 37; end
      endcase
      write_allowed(phase_allowed[p]);
      refresh_pools();
      if (phase_allowed[p] == cbfs_pkg::COUNT_MAX) begin
        // count climbs all the way to the top before the entry drops
        long_id = $urandom;
        repeat (256) send_event(cbfs_pkg::KIND_RX, long_id);
      end
      if (p == 0 || p == 3) seen_flood();
      random_traffic(80);
    end

    wait_idle(DRAIN_CYCLES);
    if (suppressor_sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
